@@ rtl/core/sgr_pkg.sv @@
package sgr_pkg;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_START  = 2'd1,
    CMD_RENDER = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_DRAW   = 2'd1,
    KIND_BREAK  = 2'd2,
    KIND_FINISH = 2'd3
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_M11     = 3'd0,
    REG_M12     = 3'd1,
    REG_M21     = 3'd2,
    REG_M22     = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_CELL_H  = 3'd6,
    REG_FILL    = 3'd7
  } reg_e;

  localparam logic [7:0]  CHAR_SPACE  = 8'h20;
  localparam logic [7:0]  PEN_UP      = 8'h80;
  localparam logic [15:0] END_MARK    = 16'h8080;
  // 0.8 in Q16.16 is 4/5 * 2^16, so the glyph numerator is 2^18.
  localparam logic [18:0] GLYPH_NUM   = 19'h40000;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic [7:0]         cell_height;
    logic               fill_mode;
  } cfg_t;

  // One job handed from the front to the back.
  typedef struct packed {
    logic               render;
    logic [11:0]        addr;
    logic [7:0]         px;
    logic [7:0]         py;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
  } job_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/sgr_ram.sv @@
module sgr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sgr_div.sv @@
module sgr_div #(
  parameter int unsigned NW = 19,
  parameter int unsigned QW = 8,
  parameter int unsigned DW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [QW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  logic [DW-1:0]          rem_q;
  logic [QW-1:0]          quo_q;
  logic [DW-1:0]          den_q;
  logic [$clog2(QW+1)-1:0] cnt_q;
  logic                   busy_q;
  logic [DW:0]            trial;
  logic                   fits;
  logic [DW:0]            diff;

  // Restoring division, one quotient bit per cycle; the caller guarantees
  // that the quotient fits in QW bits.
  assign trial = {rem_q, quo_q[QW-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= ($clog2(QW+1))'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == ($clog2(QW+1))'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DW'(num_i >> QW);
      quo_q <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/core/sgr_fifo.sv @@
module sgr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sgr_pkg::job_t job_i,
  input  logic          pop_i,
  output sgr_pkg::job_t job_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int unsigned PW = $clog2(sgr_pkg::QUEUE_DEPTH);

  sgr_pkg::job_t      slot_q [sgr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr_q;
  logic [PW-1:0]      rd_ptr_q;
  logic [PW:0]        count_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o   = slot_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (PW+1)'(sgr_pkg::QUEUE_DEPTH));

endmodule

@@ rtl/core/sgr_front.sv @@
module sgr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         char_code_i,
  input  logic [11:0]        point_address_i,
  input  logic signed [7:0]  point_x_i,
  input  logic signed [7:0]  point_y_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic               q_full_i,
  output logic               push_o,
  output sgr_pkg::job_t      job_o
);

  logic               accept;
  sgr_pkg::cmd_e      cmd;
  logic [255:0]       present_q;
  logic               stage_valid_q;
  logic [7:0]         stage_char_q;
  logic signed [31:0] stage_ox_q;
  logic signed [31:0] stage_oy_q;
  logic [11:0]        start_addr;
  logic               render_ok;

  assign cmd    = sgr_pkg::cmd_e'(cmd_i);
  assign busy   = stage_valid_q | q_full_i;
  assign accept = start & ~busy;

  // Start address table; the presence bits live in flip-flops.
  sgr_ram #(
    .WIDTH (12),
    .DEPTH (256)
  ) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (accept && cmd == sgr_pkg::CMD_START),
    .waddr_i (char_code_i),
    .wdata_i (point_address_i),
    .raddr_i (char_code_i),
    .rdata_o (start_addr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q     <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= accept && cmd == sgr_pkg::CMD_RENDER;
      if (accept && cmd == sgr_pkg::CMD_START) begin
        present_q[char_code_i] <= 1'b1;
      end
    end
  end

  // Render items wait in these registers until the table lookup returns in the next cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_char_q <= char_code_i;
      stage_ox_q   <= origin_x_i;
      stage_oy_q   <= origin_y_i;
    end
  end

  // A space or a character without a glyph is dropped here.
  assign render_ok = stage_valid_q & present_q[stage_char_q] &
                     (stage_char_q != sgr_pkg::CHAR_SPACE);

  assign push_o = render_ok | (accept && cmd == sgr_pkg::CMD_WRITE);

  always_comb begin
    job_o.render = stage_valid_q;
    job_o.ox     = stage_ox_q;
    job_o.oy     = stage_oy_q;
    job_o.px     = point_x_i;
    job_o.py     = point_y_i;
    job_o.addr   = stage_valid_q ? start_addr : point_address_i;
  end

endmodule

@@ rtl/core/sgr_back.sv @@
module sgr_back #(
  parameter int unsigned POINT_DEPTH  = 4096,
  parameter int unsigned MAX_ELEMENTS = 62
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sgr_pkg::cfg_t      cfg_i,
  input  logic               empty_i,
  input  sgr_pkg::job_t      job_i,
  output logic               pop_o,
  output logic               result_valid_o,
  output logic [1:0]         kind_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic               last_o,
  output logic               truncated_o
);

  localparam int unsigned AW = $clog2(POINT_DEPTH);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MOD   = 9'b000000010,
    ST_RECIP = 9'b000000100,
    ST_RD    = 9'b000001000,
    ST_CHK   = 9'b000010000,
    ST_DIV   = 9'b000100000,
    ST_MUL   = 9'b001000000,
    ST_FIN   = 9'b010000000,
    ST_LAST  = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  sgr_pkg::job_t      job_q;
  logic [11:0]        red_q;
  logic [16:0]        red_ext;
  logic               over_depth;
  logic [AW-1:0]      ptr_q;
  logic [AW-1:0]      ptr_next;
  logic [CW-1:0]      cnt_q;
  logic               ended_q;
  logic [2:0]         mph_q;
  logic [7:0]         mag_x_q, mag_y_q;
  logic               neg_x_q, neg_y_q;
  logic signed [31:0] xp_q, yp_q;
  logic signed [63:0] prod_q, acc_q;
  logic signed [31:0] resx_q;
  sgr_pkg::kind_e     pend_kind_q;
  logic signed [31:0] pend_x_q, pend_y_q;
  logic               valid_q;
  logic [1:0]         kind_q;
  logic signed [31:0] ox_q, oy_q;
  logic               last_q, trunc_q;

  logic [7:0]         ch_eff;
  logic [10:0]        den;
  logic               recip_busy;
  logic [18:0]        recip_quo;
  logic [10:0]        recip_rem;
  logic [15:0]        a_coef;
  logic [15:0]        pt_rdata;
  logic               is_end, is_pen_up, at_limit;
  logic [7:0]         rd_mag_x, rd_mag_y;
  logic [18:0]        num_x, num_y;
  logic               div_start;
  logic               divx_busy, divy_busy;
  logic [7:0]         divx_quo, divy_quo;
  logic [11:0]        divx_rem, divy_rem;
  logic [23:0]        off_mag_x, off_mag_y;
  logic signed [24:0] off_x, off_y;
  logic signed [31:0] xp_new, yp_new;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [64:0] sum65;
  logic signed [48:0] sum_sh;
  logic signed [31:0] shift_sel;
  logic signed [31:0] xf;
  logic               mod_done;

  // Address reduction modulo the point memory depth, one subtract a cycle.
  assign red_ext    = {5'b0, red_q};
  assign over_depth = red_ext >= 17'(POINT_DEPTH);
  assign mod_done   = (state_q == ST_MOD) && !over_depth;
  assign ptr_next   = (ptr_q == AW'(POINT_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

  // Glyph scale: 2^18 / (5 * cell_height), quotient and remainder; a cell height of zero counts as one.
  assign ch_eff = (cfg_i.cell_height == 8'd0) ? 8'd1 : cfg_i.cell_height;
  assign den    = {1'b0, ch_eff, 2'b00} + {3'b0, ch_eff};

  sgr_div #(
    .NW (19),
    .QW (19),
    .DW (11)
  ) u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pop_o),
    .num_i   (sgr_pkg::GLYPH_NUM),
    .den_i   (den),
    .busy_o  (recip_busy),
    .quo_o   (recip_quo),
    .rem_o   (recip_rem)
  );

  assign a_coef = recip_quo[15:0];

  // Point memory.
  sgr_ram #(
    .WIDTH (16),
    .DEPTH (POINT_DEPTH)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (mod_done && !job_q.render),
    .waddr_i (red_ext[AW-1:0]),
    .wdata_i ({job_q.px, job_q.py}),
    .raddr_i (ptr_q),
    .rdata_o (pt_rdata)
  );

  // Classify the element just read.
  assign is_end    = pt_rdata == sgr_pkg::END_MARK;
  assign is_pen_up = pt_rdata[15:8] == sgr_pkg::PEN_UP;
  assign at_limit  = cnt_q >= CW'(MAX_ELEMENTS);
  assign rd_mag_x  = pt_rdata[15] ? 8'(-pt_rdata[15:8]) : pt_rdata[15:8];
  assign rd_mag_y  = pt_rdata[7] ? 8'(-pt_rdata[7:0]) : pt_rdata[7:0];

  // Rounded remainder part: (2*|p|*rem + den) / (2*den).
  assign num_x = {18'(rd_mag_x * recip_rem), 1'b0} + 19'(den);
  assign num_y = {18'(rd_mag_y * recip_rem), 1'b0} + 19'(den);
  assign div_start = (state_q == ST_CHK) && !is_end && !at_limit && !is_pen_up;

  sgr_div #(
    .NW (19),
    .QW (8),
    .DW (12)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_x),
    .den_i   ({den, 1'b0}),
    .busy_o  (divx_busy),
    .quo_o   (divx_quo),
    .rem_o   (divx_rem)
  );

  sgr_div #(
    .NW (19),
    .QW (8),
    .DW (12)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_y),
    .den_i   ({den, 1'b0}),
    .busy_o  (divy_busy),
    .quo_o   (divy_quo),
    .rem_o   (divy_rem)
  );

  // Offset = |p| * quotient + rounded remainder part, signed, added to origin.
  assign off_mag_x = 24'(mag_x_q * a_coef) + {16'b0, divx_quo};
  assign off_mag_y = 24'(mag_y_q * a_coef) + {16'b0, divy_quo};
  assign off_x = neg_x_q ? -$signed({1'b0, off_mag_x}) : $signed({1'b0, off_mag_x});
  assign off_y = neg_y_q ? -$signed({1'b0, off_mag_y}) : $signed({1'b0, off_mag_y});
  assign xp_new = sgr_pkg::sat32(50'(job_q.ox) + 50'(off_x));
  assign yp_new = sgr_pkg::sat32(50'(job_q.oy) + 50'(off_y));

  // Transform: one 32x32 product per cycle, the two for the x result, then the two for the y result.
  always_comb begin
    mul_a = (mph_q == 3'd0 || mph_q == 3'd2) ? xp_q : yp_q;
    unique case (mph_q)
      3'd0:    mul_b = cfg_i.m11;
      3'd1:    mul_b = cfg_i.m21;
      3'd2:    mul_b = cfg_i.m12;
      default: mul_b = cfg_i.m22;
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign sum65     = 65'(acc_q) + 65'(prod_q);
  assign sum_sh    = $signed(sum65[64:16]);
  assign shift_sel = (mph_q == 3'd2) ? cfg_i.shift_x : cfg_i.shift_y;
  assign xf        = sgr_pkg::sat32(50'(sum_sh) + 50'(shift_sel));

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  // Walk sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) state_d = ST_MOD;
      end
      ST_MOD: begin
        if (!over_depth) state_d = job_q.render ? ST_RECIP : ST_IDLE;
      end
      ST_RECIP: begin
        if (!recip_busy) state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (is_end || at_limit) begin
          state_d = ST_FIN;
        end else if (is_pen_up) begin
          state_d = ST_RD;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!divx_busy && !divy_busy) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (mph_q == 3'd4) state_d = ST_RD;
      end
      ST_FIN: begin
        state_d = ST_LAST;
      end
      ST_LAST: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      cnt_q   <= '0;
      ptr_q   <= '0;
      mph_q   <= '0;
      ended_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= ((state_q == ST_CHK) && !is_end && !at_limit && is_pen_up) ||
                 ((state_q == ST_MUL) && mph_q == 3'd4) ||
                 ((state_q == ST_FIN) && cfg_i.fill_mode) ||
                 (state_q == ST_LAST);
      if (mod_done && job_q.render) begin
        ptr_q   <= red_ext[AW-1:0];
        cnt_q   <= '0;
        ended_q <= 1'b0;
      end
      if (state_q == ST_CHK && is_end) begin
        ended_q <= 1'b1;
      end
      if (((state_q == ST_CHK) && !is_end && !at_limit && is_pen_up) ||
          ((state_q == ST_MUL) && mph_q == 3'd4)) begin
        cnt_q <= cnt_q + 1'b1;
        ptr_q <= ptr_next;
      end
      mph_q <= (state_q == ST_MUL) ? mph_q + 1'b1 : 3'd0;
    end
  end

  // Datapath registers and the held result.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      red_q <= job_i.addr;
    end else if (state_q == ST_MOD && over_depth) begin
      red_q <= red_q - 12'(POINT_DEPTH);
    end
    if (mod_done && job_q.render) begin
      pend_kind_q <= sgr_pkg::KIND_START;
      pend_x_q    <= '0;
      pend_y_q    <= '0;
    end
    if (div_start) begin
      mag_x_q <= rd_mag_x;
      mag_y_q <= rd_mag_y;
      neg_x_q <= pt_rdata[15];
      neg_y_q <= pt_rdata[7];
    end
    if (state_q == ST_DIV) begin
      xp_q <= xp_new;
      yp_q <= yp_new;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod;
      if (mph_q == 3'd1 || mph_q == 3'd3) begin
        acc_q <= prod_q;
      end
      if (mph_q == 3'd2) begin
        resx_q <= xf;
      end
    end

    // A new element, the fill-mode finish step or the last step pushes out the held result, last only in ST_LAST.
    if (((state_q == ST_CHK) && !is_end && !at_limit && is_pen_up) ||
        ((state_q == ST_MUL) && mph_q == 3'd4) ||
        ((state_q == ST_FIN) && cfg_i.fill_mode) ||
        (state_q == ST_LAST)) begin
      kind_q  <= pend_kind_q;
      ox_q    <= pend_x_q;
      oy_q    <= pend_y_q;
      last_q  <= (state_q == ST_LAST);
      trunc_q <= (state_q == ST_LAST) && !ended_q;
    end
    if ((state_q == ST_CHK) && !is_end && !at_limit && is_pen_up) begin
      pend_kind_q <= sgr_pkg::KIND_BREAK;
      pend_x_q    <= '0;
      pend_y_q    <= '0;
    end
    if ((state_q == ST_MUL) && mph_q == 3'd4) begin
      pend_kind_q <= sgr_pkg::KIND_DRAW;
      pend_x_q    <= resx_q;
      pend_y_q    <= xf;
    end
    if ((state_q == ST_FIN) && cfg_i.fill_mode) begin
      pend_kind_q <= sgr_pkg::KIND_FINISH;
      pend_x_q    <= '0;
      pend_y_q    <= '0;
    end
  end

  assign result_valid_o = valid_q;
  assign kind_o         = kind_q;
  assign out_x_o        = ox_q;
  assign out_y_o        = oy_q;
  assign last_o         = last_q;
  assign truncated_o    = trunc_q;

endmodule

@@ rtl/core/stroke_glyph_renderer_unit.sv @@
// Load items are taken at the port; a render lookup keeps busy high while its
// table read returns. Point writes go through the job queue to the walker's
// address wrap step. A render runs a setup (address wrap plus the 19-step scale
// divide), a read and check per pen-up, an 8-step rounding divide and four 32x32
// products per drawn point, and a finish. The walker sets the sustained rate.
// Reset clears all glyph starts at once; the point memory holds no reset value.
module stroke_glyph_renderer_unit #(
  parameter int unsigned POINT_DEPTH  = 4096,
  parameter int unsigned MAX_ELEMENTS = 62
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         char_code_i,
  input  logic [11:0]        point_address_i,
  input  logic signed [7:0]  point_x_i,
  input  logic signed [7:0]  point_y_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  output logic               result_valid_o,
  output logic [1:0]         kind_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic               last_o,
  output logic               truncated_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  sgr_pkg::cfg_t cfg_q;
  sgr_pkg::reg_e reg_idx;
  logic          cfg_wr;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  sgr_pkg::job_t push_job;
  sgr_pkg::job_t head_job;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = sgr_pkg::reg_e'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.m11         <= 32'sd65536;
      cfg_q.m12         <= '0;
      cfg_q.m21         <= '0;
      cfg_q.m22         <= 32'sd65536;
      cfg_q.shift_x     <= '0;
      cfg_q.shift_y     <= '0;
      cfg_q.cell_height <= 8'd16;
      cfg_q.fill_mode   <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sgr_pkg::REG_M11:     cfg_q.m11         <= pwdata;
        sgr_pkg::REG_M12:     cfg_q.m12         <= pwdata;
        sgr_pkg::REG_M21:     cfg_q.m21         <= pwdata;
        sgr_pkg::REG_M22:     cfg_q.m22         <= pwdata;
        sgr_pkg::REG_SHIFT_X: cfg_q.shift_x     <= pwdata;
        sgr_pkg::REG_SHIFT_Y: cfg_q.shift_y     <= pwdata;
        sgr_pkg::REG_CELL_H:  cfg_q.cell_height <= pwdata[7:0];
        sgr_pkg::REG_FILL:    cfg_q.fill_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      sgr_pkg::REG_M11:     prdata = cfg_q.m11;
      sgr_pkg::REG_M12:     prdata = cfg_q.m12;
      sgr_pkg::REG_M21:     prdata = cfg_q.m21;
      sgr_pkg::REG_M22:     prdata = cfg_q.m22;
      sgr_pkg::REG_SHIFT_X: prdata = cfg_q.shift_x;
      sgr_pkg::REG_SHIFT_Y: prdata = cfg_q.shift_y;
      sgr_pkg::REG_CELL_H:  prdata = {24'b0, cfg_q.cell_height};
      sgr_pkg::REG_FILL:    prdata = {31'b0, cfg_q.fill_mode};
      default:              prdata = '0;
    endcase
  end

  sgr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .char_code_i     (char_code_i),
    .point_address_i (point_address_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .origin_x_i      (origin_x_i),
    .origin_y_i      (origin_y_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .job_o           (push_job)
  );

  sgr_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  sgr_back #(
    .POINT_DEPTH  (POINT_DEPTH),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .empty_i        (q_empty),
    .job_i          (head_job),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .last_o         (last_o),
    .truncated_o    (truncated_o)
  );

endmodule
